// File: design/glw_pkg.sv
`timescale 1ns / 1ps

package glw_pkg;

    // Request function codes
    typedef enum logic
    {
        FUNC_LOAD = 1'b0,
        FUNC_NEXT = 1'b1
    } func_t;

    // Two-bit signed unit step per axis
    localparam logic [1:0] STEP_ZERO = 2'b00;
    localparam logic [1:0] STEP_POS  = 2'b01;
    localparam logic [1:0] STEP_NEG  = 2'b11;

endpackage

// File: design/glw_req_if.sv
`timescale 1ns / 1ps

interface glw_req_if #(parameter int COORD_BITS = 16) ();
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, func, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, func, start_x, start_y, end_x, end_y, output ready);
endinterface

// File: design/glw_rsp_if.sv
`timescale 1ns / 1ps

interface glw_rsp_if #(parameter int COORD_BITS = 16) ();
    logic                           valid;
    logic                           ready;
    logic signed [COORD_BITS+1:0]   point_x;
    logic signed [COORD_BITS+1:0]   point_y;
    logic                           last;
    logic                           no_line;

    modport source (output valid, point_x, point_y, last, no_line, input ready);
    modport sink   (input valid, point_x, point_y, last, no_line, output ready);
endinterface

// File: design/glw_in_reg.sv
`timescale 1ns / 1ps

module glw_in_reg #(parameter int COORD_BITS = 16)
(
    input  logic      clk,
    input  logic      rst_n,
    glw_req_if.sink   req,
    glw_req_if.source q
);

    logic                         valid_reg;
    logic                         valid_next;
    logic                         func_reg;
    logic signed [COORD_BITS-1:0] start_x_reg;
    logic signed [COORD_BITS-1:0] start_y_reg;
    logic signed [COORD_BITS-1:0] end_x_reg;
    logic signed [COORD_BITS-1:0] end_y_reg;

    // Take a new beat whenever the held one leaves this cycle
    assign req.ready = !valid_reg || q.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.ready)
        begin
            valid_next = req.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            func_reg    <= req.func;
            start_x_reg <= req.start_x;
            start_y_reg <= req.start_y;
            end_x_reg   <= req.end_x;
            end_y_reg   <= req.end_y;
        end
    end

    assign q.valid   = valid_reg;
    assign q.func    = func_reg;
    assign q.start_x = start_x_reg;
    assign q.start_y = start_y_reg;
    assign q.end_x   = end_x_reg;
    assign q.end_y   = end_y_reg;

endmodule

// File: design/glw_step_core.sv
`timescale 1ns / 1ps

module glw_step_core
    import glw_pkg::*;
#(parameter int COORD_BITS = 16)
(
    input  logic      clk,
    input  logic      rst_n,
    glw_req_if.sink   q,
    glw_rsp_if.source r
);

    localparam int OW = COORD_BITS + 2;
    localparam int EW = COORD_BITS + 3;
    localparam int TW = COORD_BITS + 1;

    logic signed [OW-1:0]         cur_x_reg, cur_x_next;
    logic signed [OW-1:0]         cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] target_x_reg, target_x_next;
    logic signed [COORD_BITS-1:0] target_y_reg, target_y_next;
    logic [1:0]                   step_x_reg, step_x_next;
    logic [1:0]                   step_y_reg, step_y_next;
    logic [TW-1:0]                twice_dx_reg, twice_dx_next;
    logic [TW-1:0]                twice_dy_reg, twice_dy_next;
    logic signed [EW-1:0]         error_acc_reg, error_acc_next;
    logic signed [OW-1:0]         box_x_low_reg, box_x_low_next;
    logic signed [OW-1:0]         box_x_high_reg, box_x_high_next;
    logic signed [OW-1:0]         box_y_low_reg, box_y_low_next;
    logic signed [OW-1:0]         box_y_high_reg, box_y_high_next;
    logic                         line_active_reg, line_active_next;

    // Load path
    logic signed [TW-1:0]         dx, dy, ndx, ndy;
    logic [COORD_BITS-1:0]        adx, ady;
    logic signed [COORD_BITS-1:0] min_x, max_x, min_y, max_y;

    // Step path
    logic signed [OW-1:0]         sx_ext, sy_ext;
    logic signed [EW-1:0]         tdx_ext, tdy_ext;
    logic signed [OW-1:0]         tgt_x_ext, tgt_y_ext;
    logic signed [OW-1:0]         new_x, new_y;
    logic signed [EW-1:0]         new_err;
    logic                         err_pos;
    logic                         at_end;
    logic                         in_box;
    logic                         is_last;
    logic                         is_load;

    assign is_load = (q.func == FUNC_LOAD);

    // A load never produces a beat; a next request needs room downstream
    assign q.ready = is_load || r.ready;
    assign r.valid = q.valid && !is_load;

    always_comb
    begin
        dx  = $signed({q.end_x[COORD_BITS-1], q.end_x})
            - $signed({q.start_x[COORD_BITS-1], q.start_x});
        dy  = $signed({q.end_y[COORD_BITS-1], q.end_y})
            - $signed({q.start_y[COORD_BITS-1], q.start_y});
        ndx = -dx;
        ndy = -dy;
        adx = dx[TW-1] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ady = dy[TW-1] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        min_x = (q.start_x < q.end_x) ? q.start_x : q.end_x;
        max_x = (q.start_x < q.end_x) ? q.end_x : q.start_x;
        min_y = (q.start_y < q.end_y) ? q.start_y : q.end_y;
        max_y = (q.start_y < q.end_y) ? q.end_y : q.start_y;
    end

    always_comb
    begin
        sx_ext    = $signed({{COORD_BITS{step_x_reg[1]}}, step_x_reg});
        sy_ext    = $signed({{COORD_BITS{step_y_reg[1]}}, step_y_reg});
        tdx_ext   = $signed({2'b00, twice_dx_reg});
        tdy_ext   = $signed({2'b00, twice_dy_reg});
        tgt_x_ext = $signed({{2{target_x_reg[COORD_BITS-1]}}, target_x_reg});
        tgt_y_ext = $signed({{2{target_y_reg[COORD_BITS-1]}}, target_y_reg});
        err_pos   = !error_acc_reg[EW-1] && (error_acc_reg != '0);
        new_x     = cur_x_reg;
        new_y     = cur_y_reg;
        new_err   = error_acc_reg;
        priority if (twice_dx_reg == twice_dy_reg)
        begin
            new_x = cur_x_reg + sx_ext;
            new_y = cur_y_reg + sy_ext;
        end
        else if (twice_dx_reg > twice_dy_reg)
        begin
            // x-major: minor step on y when the error is positive
            if (err_pos)
            begin
                new_y   = cur_y_reg + sy_ext;
                new_err = error_acc_reg - tdx_ext + tdy_ext;
            end
            else
            begin
                new_err = error_acc_reg + tdy_ext;
            end
            new_x = cur_x_reg + sx_ext;
        end
        else
        begin
            if (err_pos)
            begin
                new_x   = cur_x_reg + sx_ext;
                new_err = error_acc_reg - tdy_ext + tdx_ext;
            end
            else
            begin
                new_err = error_acc_reg + tdx_ext;
            end
            new_y = cur_y_reg + sy_ext;
        end
        at_end  = (new_x == tgt_x_ext) && (new_y == tgt_y_ext);
        in_box  = (new_x >= box_x_low_reg) && (new_x <= box_x_high_reg)
               && (new_y >= box_y_low_reg) && (new_y <= box_y_high_reg);
        is_last = at_end || !in_box;
    end

    always_comb
    begin
        r.point_x = '0;
        r.point_y = '0;
        r.last    = 1'b0;
        r.no_line = 1'b1;
        if (line_active_reg)
        begin
            r.point_x = new_x;
            r.point_y = new_y;
            r.last    = is_last;
            r.no_line = 1'b0;
        end
    end

    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        target_x_next    = target_x_reg;
        target_y_next    = target_y_reg;
        step_x_next      = step_x_reg;
        step_y_next      = step_y_reg;
        twice_dx_next    = twice_dx_reg;
        twice_dy_next    = twice_dy_reg;
        error_acc_next   = error_acc_reg;
        box_x_low_next   = box_x_low_reg;
        box_x_high_next  = box_x_high_reg;
        box_y_low_next   = box_y_low_reg;
        box_y_high_next  = box_y_high_reg;
        line_active_next = line_active_reg;
        if (q.valid && q.ready)
        begin
            if (is_load)
            begin
                cur_x_next       = $signed({{2{q.start_x[COORD_BITS-1]}}, q.start_x});
                cur_y_next       = $signed({{2{q.start_y[COORD_BITS-1]}}, q.start_y});
                target_x_next    = q.end_x;
                target_y_next    = q.end_y;
                twice_dx_next    = {adx, 1'b0};
                twice_dy_next    = {ady, 1'b0};
                step_x_next      = (dx == '0) ? STEP_ZERO : (dx[TW-1] ? STEP_NEG : STEP_POS);
                step_y_next      = (dy == '0) ? STEP_ZERO : (dy[TW-1] ? STEP_NEG : STEP_POS);
                error_acc_next   = '0;
                box_x_low_next   = $signed({{2{min_x[COORD_BITS-1]}}, min_x})
                                 - $signed({2'b00, adx});
                box_x_high_next  = $signed({{2{max_x[COORD_BITS-1]}}, max_x})
                                 + $signed({2'b00, adx});
                box_y_low_next   = $signed({{2{min_y[COORD_BITS-1]}}, min_y})
                                 - $signed({2'b00, ady});
                box_y_high_next  = $signed({{2{max_y[COORD_BITS-1]}}, max_y})
                                 + $signed({2'b00, ady});
                line_active_next = 1'b1;
            end
            else if (line_active_reg)
            begin
                cur_x_next       = new_x;
                cur_y_next       = new_y;
                error_acc_next   = new_err;
                line_active_next = !is_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            step_x_reg      <= STEP_ZERO;
            step_y_reg      <= STEP_ZERO;
            twice_dx_reg    <= '0;
            twice_dy_reg    <= '0;
            error_acc_reg   <= '0;
            box_x_low_reg   <= '0;
            box_x_high_reg  <= '0;
            box_y_low_reg   <= '0;
            box_y_high_reg  <= '0;
            line_active_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            target_x_reg    <= target_x_next;
            target_y_reg    <= target_y_next;
            step_x_reg      <= step_x_next;
            step_y_reg      <= step_y_next;
            twice_dx_reg    <= twice_dx_next;
            twice_dy_reg    <= twice_dy_next;
            error_acc_reg   <= error_acc_next;
            box_x_low_reg   <= box_x_low_next;
            box_x_high_reg  <= box_x_high_next;
            box_y_low_reg   <= box_y_low_next;
            box_y_high_reg  <= box_y_high_next;
            line_active_reg <= line_active_next;
        end
    end

endmodule

// File: design/glw_out_reg.sv
`timescale 1ns / 1ps

module glw_out_reg #(parameter int COORD_BITS = 16)
(
    input  logic      clk,
    input  logic      rst_n,
    glw_rsp_if.sink   r,
    glw_rsp_if.source rsp
);

    logic                         valid_reg;
    logic                         valid_next;
    logic signed [COORD_BITS+1:0] point_x_reg;
    logic signed [COORD_BITS+1:0] point_y_reg;
    logic                         last_reg;
    logic                         no_line_reg;

    // Refill in the same cycle the held beat is taken
    assign r.ready = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (r.ready)
        begin
            valid_next = r.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r.valid && r.ready)
        begin
            point_x_reg <= r.point_x;
            point_y_reg <= r.point_y;
            last_reg    <= r.last;
            no_line_reg <= r.no_line;
        end
    end

    assign rsp.valid   = valid_reg;
    assign rsp.point_x = point_x_reg;
    assign rsp.point_y = point_y_reg;
    assign rsp.last    = last_reg;
    assign rsp.no_line = no_line_reg;

endmodule

// File: design/grid_line_point_walker.sv
`timescale 1ns / 1ps

// Grid line point walker. A load beat (func = 0) sets up a line from its start
// and end coordinates and produces no response; every next beat (func = 1)
// advances one grid step and returns the new point, not the start itself unless
// start and end coincide. The point carries last when it hits the end or leaves
// the safety box (the endpoints' bounding box widened by the deltas); after that,
// and after reset, next beats return no_line with zero point fields. Throughput
// is one beat per clock while the response sink is ready: a beat is held in the
// input register, the step logic updates the line state as the beat leaves it,
// and the response sits in the output register. The step loop through the line
// state registers sets that rate.

module grid_line_point_walker #(parameter int COORD_BITS = 16)
(
    input  logic      clk,
    input  logic      rst_n,
    glw_req_if.sink   req,
    glw_rsp_if.source rsp
);

    // Registered request toward the step logic
    glw_req_if #(.COORD_BITS(COORD_BITS)) q_ch ();
    // Step result toward the output register
    glw_rsp_if #(.COORD_BITS(COORD_BITS)) r_ch ();

    // Register the incoming beat until the step logic takes it
    glw_in_reg #(.COORD_BITS(COORD_BITS)) u_in_reg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .q     (q_ch)
    );

    // Load a line or advance one step on the held beat
    glw_step_core #(.COORD_BITS(COORD_BITS)) u_step_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .q     (q_ch),
        .r     (r_ch)
    );

    // Hold the response until the sink takes it
    glw_out_reg #(.COORD_BITS(COORD_BITS)) u_out_reg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .r     (r_ch),
        .rsp   (rsp)
    );

endmodule
